// ===== design/sird_pkg.sv =====
package sird_pkg;

  localparam int MAX_BASE_DEF = 16;
  localparam int NUM_SYMS = 16;
  localparam int SYM_W = 8;
  localparam int NUM_W = 32;
  localparam int LEN_W = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 64;
  localparam int SYM_IDX_W = 4;
  localparam int STEPS_PER_CYCLE = 8;
  localparam int CYCLES_PER_DIGIT = NUM_W / STEPS_PER_CYCLE;
  localparam int STEP_CNT_W = $clog2(CYCLES_PER_DIGIT);
  localparam int MAX_DIGITS = NUM_W;
  localparam int DIG_CNT_W = $clog2(MAX_DIGITS) + 1;
  localparam int DIG_IDX_W = $clog2(MAX_DIGITS);

  localparam logic [CFG_IDX_W-1:0] REG_BASE_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_LOW = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_HIGH = 2'd2;

  localparam logic [LEN_W-1:0] BASE_LENGTH_RST = 5'd10;
  localparam logic [CFG_DATA_W-1:0] SYMBOLS_LOW_RST = 64'h3736353433323130;
  localparam logic [CFG_DATA_W-1:0] SYMBOLS_HIGH_RST = 64'h0000000000003938;

  localparam logic [SYM_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [SYM_W-1:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [SYM_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [SYM_W-1:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [SYM_W-1:0] CHAR_DIGIT_0 = 8'h30;
  localparam logic [SYM_W-1:0] CHAR_DIGIT_9 = 8'h39;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIVIDE,
    ST_SIGN,
    ST_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic capture;
    logic start_div;
    logic div_step;
    logic emit_sign;
    logic emit_digit;
  } dp_cmd_t;

  typedef struct packed {
    logic base_ok;
    logic neg;
    logic div_last;
    logic quo_zero;
    logic out_free;
    logic last_digit;
  } dp_status_t;

  function automatic logic is_alnum(input logic [SYM_W-1:0] c);
    return (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) ||
           (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ||
           (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9);
  endfunction

endpackage

// ===== design/sird_ctrl.sv =====
module sird_ctrl import sird_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    item_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.capture = 1'b1;
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (status.base_ok) begin
          cmd.start_div = 1'b1;
          state_next = ST_DIVIDE;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (status.div_last && status.quo_zero) begin
          state_next = ST_SIGN;
        end
      end
      ST_SIGN: begin
        if (!status.neg) begin
          state_next = ST_EMIT;
        end else if (status.out_free) begin
          cmd.emit_sign = 1'b1;
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit_digit = 1'b1;
          if (status.last_digit) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== design/sird_datapath.sv =====
module sird_datapath import sird_pkg::*; #(
  parameter int MAX_BASE = MAX_BASE_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic signed [NUM_W-1:0] number,
  input  dp_cmd_t                 cmd,
  output dp_status_t              status,
  output logic [SYM_W-1:0]        character,
  output logic                    last_char,
  output logic                    result_valid,
  input  logic                    result_ready
);

  localparam int DIG_W = $clog2(MAX_BASE);

  logic [LEN_W-1:0]      base_length;
  logic [CFG_DATA_W-1:0] symbols_low;
  logic [CFG_DATA_W-1:0] symbols_high;
  logic                  base_ok;
  logic                  base_ok_next;
  logic                  neg;
  logic [NUM_W-1:0]      quo;
  logic [NUM_W-1:0]      quo_next;
  logic [DIG_W-1:0]      rem;
  logic [DIG_W-1:0]      rem_next;
  logic [STEP_CNT_W-1:0] step_cnt;
  logic [DIG_CNT_W-1:0]  ndig;
  logic [DIG_W-1:0]      digits [MAX_DIGITS];
  logic [2*CFG_DATA_W-1:0] sym_tbl;
  logic [DIG_W:0]        len_w;
  logic [DIG_IDX_W-1:0]  rd_idx;
  logic [DIG_IDX_W-1:0]  rd_idx_after;
  logic [DIG_W-1:0]      rd_digit;
  logic [SYM_IDX_W-1:0]  sym_idx;
  logic [SYM_W-1:0]      rd_sym;
  logic                  out_free;

  assign sym_tbl = {symbols_high, symbols_low};
  assign len_w = base_length[DIG_W:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      base_length <= BASE_LENGTH_RST;
      symbols_low <= SYMBOLS_LOW_RST;
      symbols_high <= SYMBOLS_HIGH_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_BASE_LENGTH:  base_length <= cfg_data[LEN_W-1:0];
        REG_SYMBOLS_LOW:  symbols_low <= cfg_data;
        REG_SYMBOLS_HIGH: symbols_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // base check: length in range, symbols alphanumeric and distinct
  always_comb begin
    base_ok_next = (base_length >= LEN_W'(2)) && (base_length <= LEN_W'(MAX_BASE));
    for (int i = 0; i < NUM_SYMS; i++) begin
      if (LEN_W'(i) < base_length) begin
        if (!is_alnum(sym_tbl[SYM_W*i +: SYM_W])) begin
          base_ok_next = 1'b0;
        end
        for (int j = i + 1; j < NUM_SYMS; j++) begin
          if (LEN_W'(j) < base_length &&
              sym_tbl[SYM_W*i +: SYM_W] == sym_tbl[SYM_W*j +: SYM_W]) begin
            base_ok_next = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    base_ok <= base_ok_next;
  end

  // restoring division, several quotient bits per cycle
  always_comb begin
    logic [DIG_W:0] trial;
    quo_next = quo;
    rem_next = rem;
    for (int s = 0; s < STEPS_PER_CYCLE; s++) begin
      trial = {rem_next, quo_next[NUM_W-1]};
      if (trial >= len_w) begin
        trial = trial - len_w;
        quo_next = {quo_next[NUM_W-2:0], 1'b1};
      end else begin
        quo_next = {quo_next[NUM_W-2:0], 1'b0};
      end
      rem_next = trial[DIG_W-1:0];
    end
  end

  assign rd_idx = DIG_IDX_W'(ndig - DIG_CNT_W'(1));
  assign rd_idx_after = DIG_IDX_W'(ndig - DIG_CNT_W'(2));

  // registered digit read, next digit fetched while one is sent
  always_ff @(posedge clk) begin
    if (cmd.emit_digit) begin
      rd_digit <= digits[rd_idx_after];
    end else begin
      rd_digit <= digits[rd_idx];
    end
  end

  assign sym_idx = SYM_IDX_W'(rd_digit);
  assign rd_sym = sym_tbl[SYM_W*sym_idx +: SYM_W];
  assign out_free = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      neg <= number[NUM_W-1];
      quo <= number[NUM_W-1] ? (NUM_W'(0) - NUM_W'(number)) : NUM_W'(number);
    end else if (cmd.div_step) begin
      quo <= quo_next;
    end
    if (cmd.start_div) begin
      rem <= '0;
      step_cnt <= '0;
      ndig <= '0;
    end else if (cmd.div_step) begin
      step_cnt <= step_cnt + STEP_CNT_W'(1);
      if (step_cnt == STEP_CNT_W'(CYCLES_PER_DIGIT - 1)) begin
        digits[ndig[DIG_IDX_W-1:0]] <= rem_next;
        ndig <= ndig + DIG_CNT_W'(1);
        rem <= '0;
      end else begin
        rem <= rem_next;
      end
    end else if (cmd.emit_digit) begin
      ndig <= ndig - DIG_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit_sign || cmd.emit_digit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      character <= CHAR_MINUS;
      last_char <= 1'b0;
    end else if (cmd.emit_digit) begin
      character <= rd_sym;
      last_char <= (ndig == DIG_CNT_W'(1));
    end
  end

  assign status.base_ok = base_ok;
  assign status.neg = neg;
  assign status.div_last = (step_cnt == STEP_CNT_W'(CYCLES_PER_DIGIT - 1));
  assign status.quo_zero = (quo_next == '0);
  assign status.out_free = out_free;
  assign status.last_digit = (ndig == DIG_CNT_W'(1));

endmodule

// ===== design/signed_int_to_radix_digits.sv =====
// signed integer to text in a configurable radix
//
// input channel (item_valid/item_ready/number): one signed 32-bit request.
// result channel (result_valid/result_ready): one character per result,
// minus sign first for negative values, then digits most significant first,
// last_char set on the final digit. an invalid base gives no results.
// config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 base
// length, 1 symbols 0..7, 2 symbols 8..15; always ready, write only while idle.
//
// a request takes as long with or without a minus sign until its last
// character sits in the output register, if the receiver does not stall;
// each digit is one pass of the shared divider (8 quotient bits per cycle
// over 32 bits), then characters leave one per cycle while the receiver is ready.
// base ten needs at most 10 digits, base two up to 32.
// one request is handled at a time; the block is ready for the next in the
// same cycle as the last character sits in the output register.
// reset restores base ten with symbols 0..9 and empties the output register.
// a stalled receiver holds the output register and pauses the block at its next character.
module signed_int_to_radix_digits import sird_pkg::*; #(
  parameter int MAX_BASE = MAX_BASE_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic                    item_valid,
  output logic                    item_ready,
  input  logic signed [NUM_W-1:0] number,
  output logic                    result_valid,
  input  logic                    result_ready,
  output logic [SYM_W-1:0]        character,
  output logic                    last_char
);

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  sird_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .status     (status),
    .cmd        (cmd)
  );

  sird_datapath #(
    .MAX_BASE (MAX_BASE)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .number       (number),
    .cmd          (cmd),
    .status       (status),
    .character    (character),
    .last_char    (last_char),
    .result_valid (result_valid),
    .result_ready (result_ready)
  );

endmodule

// ===== design/sird_checker.sv =====
module sird_checker import sird_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             item_valid,
  input logic             item_ready,
  input logic             result_valid,
  input logic             result_ready,
  input logic [SYM_W-1:0] character,
  input logic             last_char
);

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(character) && $stable(last_char))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

  a_one_request: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("second request taken while busy");

  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && character == CHAR_MINUS |-> !last_char)
    else $error("minus sign marked last");

endmodule

bind signed_int_to_radix_digits sird_checker u_sird_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .character    (character),
  .last_char    (last_char)
);

// ===== sim/signed_int_to_radix_digits_tb.sv =====
`timescale 1ns / 1ps

module signed_int_to_radix_digits_tb;
  import sird_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 200;
  localparam int LONG_HOLD = 400;
  localparam int HALF_ITEMS = 24;

  typedef struct packed {
    logic [SYM_W-1:0] ch;
    logic             last;
  } text_char_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;
  logic                    item_valid = 1'b0;
  logic                    item_ready;
  logic signed [NUM_W-1:0] number = '0;
  logic                    result_valid;
  logic                    result_ready = 1'b0;
  logic [SYM_W-1:0]        character;
  logic                    last_char;

  // shadow of the block's registers
  logic [LEN_W-1:0]      radix = BASE_LENGTH_RST;
  logic [CFG_DATA_W-1:0] sym_lo = SYMBOLS_LOW_RST;
  logic [CFG_DATA_W-1:0] sym_hi = SYMBOLS_HIGH_RST;

  logic [NUM_W-1:0] numbers_to_send[$];
  text_char_t       expected_chars[$];

  int   errors = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   hold_seq = 0;
  int   hold_seen = 0;
  int   hold_left = 0;
  int   idle_cycles = 0;
  logic item_taken = 1'b0;

  signed_int_to_radix_digits dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .number      (number),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .character   (character),
    .last_char   (last_char)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [SYM_W-1:0] symbol_of(input logic [SYM_IDX_W-1:0] idx);
    logic [2*CFG_DATA_W-1:0] sym_all;
    sym_all = {sym_hi, sym_lo};
    return sym_all[idx*SYM_W +: SYM_W];
  endfunction

  function automatic logic alnum(input logic [SYM_W-1:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9");
  endfunction

  function automatic logic radix_ok();
    logic [SYM_W-1:0] c;
    if (radix < 2 || radix > MAX_BASE_DEF) return 1'b0;
    for (int i = 0; i < radix; i++) begin
      c = symbol_of(i[SYM_IDX_W-1:0]);
      if (!alnum(c)) return 1'b0;
      for (int j = i + 1; j < radix; j++) begin
        if (symbol_of(j[SYM_IDX_W-1:0]) == c) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic void predict_text(input logic [NUM_W-1:0] raw);
    logic [NUM_W-1:0] mag;
    logic [SYM_W-1:0] digits[$];
    if (!radix_ok()) return;
    mag = raw;
    if (raw[NUM_W-1]) begin
      mag = -raw;
      expected_chars.push_back('{ch: CHAR_MINUS, last: 1'b0});
    end
    if (mag == 0) digits.push_front(symbol_of('0));
    while (mag != 0) begin
      digits.push_front(symbol_of(SYM_IDX_W'(mag % radix)));
      mag = mag / radix;
    end
    foreach (digits[k]) begin
      expected_chars.push_back('{ch: digits[k], last: (k == digits.size() - 1)});
    end
  endfunction

  function automatic logic [NUM_W-1:0] random_number();
    logic [NUM_W-1:0] v;
    case ($urandom_range(3))
      0: v = $urandom;
      1: v = $urandom_range(40);
      2: v = $urandom >> $urandom_range(31);
      default: v = 32'h7FFFFFFF - $urandom_range(20);
    endcase
    if ($urandom_range(1)) v = -v;
    return v;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_BASE_LENGTH: radix = val[LEN_W-1:0];
      REG_SYMBOLS_LOW: sym_lo = val;
      REG_SYMBOLS_HIGH: sym_hi = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // wait until every request is taken and every character has come
  task automatic settle(input int extra);
    @(posedge clk);
    while (numbers_to_send.size() != 0 || item_valid || expected_chars.size() != 0)
      @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic random_base(input int len, input logic spoil);
    logic [SYM_W-1:0]        pool[62];
    logic [SYM_W-1:0]        tmp;
    logic [2*CFG_DATA_W-1:0] syms;
    int                      j;
    for (int i = 0; i < 26; i++) begin
      pool[i] = "a" + 8'(i);
      pool[26 + i] = "A" + 8'(i);
    end
    for (int i = 0; i < 10; i++) pool[52 + i] = "0" + 8'(i);
    for (int i = 61; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = pool[i];
      pool[i] = pool[j];
      pool[j] = tmp;
    end
    syms = {$urandom, $urandom, $urandom, $urandom};
    for (int i = 0; i < len; i++) syms[i*SYM_W +: SYM_W] = pool[i];
    if (spoil) begin
      j = $urandom_range(len - 1);
      if ($urandom_range(1)) begin
        syms[j*SYM_W +: SYM_W] = pool[(j + 1) % len];
      end else begin
        do tmp = 8'($urandom); while (alnum(tmp));
        syms[j*SYM_W +: SYM_W] = tmp;
      end
    end
    write_reg(REG_SYMBOLS_LOW, syms[CFG_DATA_W-1:0]);
    write_reg(REG_SYMBOLS_HIGH, syms[2*CFG_DATA_W-1:CFG_DATA_W]);
    write_reg(REG_BASE_LENGTH, CFG_DATA_W'(len));
  endtask

  task automatic random_phase(input int send_pct, input int stall_pct, input logic long_hold);
    send_idle_pct = send_pct;
    recv_stall_pct = stall_pct;
    for (int half = 0; half < 2; half++) begin
      random_base($urandom_range(2, MAX_BASE_DEF), !long_hold && $urandom_range(9) == 0);
      if (long_hold && half == 0) hold_seq++;
      repeat (HALF_ITEMS) numbers_to_send.push_back(random_number());
      settle(SETTLE_CYCLES);
    end
  endtask

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || item_taken) begin
      if (numbers_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        number <= numbers_to_send.pop_front();
        item_valid <= 1'b1;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // result receiver
  always @(negedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else if (hold_left > 0) begin
      result_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_seq) begin
      hold_seen <= hold_seq;
      hold_left <= LONG_HOLD;
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : text_check
    text_char_t want;
    if (rst) begin
      item_taken <= 1'b0;
    end else begin
      item_taken <= item_valid && item_ready;
      if (item_valid && item_ready) predict_text(number);
      if (result_valid && result_ready) begin
        if (expected_chars.size() == 0) begin
          errors++;
          $display("%0t: character %h with nothing expected", $time, character);
        end else begin
          want = expected_chars.pop_front();
          if (character !== want.ch) begin
            errors++;
            $display("%0t: character expected %h actual %h", $time, want.ch, character);
          end
          if (last_char !== want.last) begin
            errors++;
            $display("%0t: last_char expected %b actual %b", $time, want.last, last_char);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // base ten after reset
    numbers_to_send = '{32'd0, 32'd1, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'd10};
    settle(0);

    // base two, longest text
    write_reg(REG_BASE_LENGTH, 64'd2);
    numbers_to_send = '{32'h80000000, 32'h7FFFFFFF, 32'd5};
    settle(0);

    // base sixteen
    write_reg(REG_SYMBOLS_HIGH, 64'h6665646362613938);
    write_reg(REG_BASE_LENGTH, 64'd16);
    numbers_to_send = '{32'h80000000, 32'hDEADBEEF, 32'hFFFFFFFF};
    settle(0);

    // radix below two and above the maximum
    write_reg(REG_BASE_LENGTH, 64'd0);
    numbers_to_send.push_back(32'd7);
    settle(SETTLE_CYCLES);
    write_reg(REG_BASE_LENGTH, 64'd1);
    numbers_to_send.push_back(32'hFFFFFFF9);
    settle(SETTLE_CYCLES);
    write_reg(REG_BASE_LENGTH, 64'd17);
    numbers_to_send.push_back(32'd123);
    settle(SETTLE_CYCLES);
    write_reg(REG_BASE_LENGTH, 64'd31);
    numbers_to_send.push_back(32'd0);
    settle(SETTLE_CYCLES);

    // bad symbols, all ones and a zero byte
    write_reg(REG_SYMBOLS_HIGH, 64'hFFFFFFFFFFFFFFFF);
    write_reg(REG_BASE_LENGTH, 64'd16);
    numbers_to_send.push_back(32'd99);
    settle(SETTLE_CYCLES);
    write_reg(REG_SYMBOLS_HIGH, SYMBOLS_HIGH_RST);
    write_reg(REG_BASE_LENGTH, 64'd11);
    numbers_to_send.push_back(32'd42);
    settle(SETTLE_CYCLES);

    // repeated symbol
    write_reg(REG_SYMBOLS_LOW, 64'h3036353433323130);
    write_reg(REG_BASE_LENGTH, 64'd8);
    numbers_to_send.push_back(32'd64);
    settle(SETTLE_CYCLES);

    // unused bytes ignored, upper length bits dropped
    write_reg(REG_SYMBOLS_LOW, 64'hFFFFFFFFFF7A4139);
    write_reg(REG_BASE_LENGTH, 64'hFFFFFFFFFFFFFFE3);
    numbers_to_send = '{32'hFFFFCFC7, 32'd0};
    settle(0);

    // write to an index beyond the register set
    write_reg(REG_UNUSED, 64'd0);
    numbers_to_send.push_back(32'd8);
    settle(SETTLE_CYCLES);

    random_phase(0, 0, 1'b1);
    random_phase(68, 0, 1'b0);
    random_phase(0, 68, 1'b0);
    random_phase(10, 10, 1'b0);

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/sird_pkg.sv
design/sird_ctrl.sv
design/sird_datapath.sv
design/signed_int_to_radix_digits.sv
design/sird_checker.sv
sim/signed_int_to_radix_digits_tb.sv
